// ===== hdl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared constants, command/status structs and helpers for the depth first
// search discovery/finish time block.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // Graph size and derived widths
  localparam int MaxVertices = 32;
  localparam int VIdxW       = $clog2(MaxVertices);
  localparam int CntW        = VIdxW + 1;
  localparam int TimeW       = CntW + 1;

  // Fixed field widths of the request and result ports
  localparam int EdgeW   = 6;
  localparam int VcW     = 6;
  localparam int SvW     = 5;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 6;
  localparam int OutIdxW = 5;
  localparam int OutTimW = 7;

  // Request kinds
  localparam logic KindAddEdge = 1'b0;
  localparam logic KindRun     = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgVertexCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStartVertex = 1'b1;

  localparam logic [VcW-1:0] VertexCountRst = VcW'(MaxVertices);

  // Controller to datapath commands
  typedef struct packed {
    logic add_edge;    // set one adjacency bit
    logic run_init;    // clear marks, time and stack; rewind emit index
    logic disc_start;  // discover the configured start vertex as a root
    logic disc_sweep;  // discover the lowest unvisited vertex as a root
    logic disc_cand;   // push current vertex, discover its candidate
    logic finish;      // stamp finish of current vertex, pop if possible
    logic emit;        // load one result into the output register
    logic clear_adj;   // wipe the adjacency matrix
  } dfs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cand_found;  // current vertex has an unvisited live neighbor
    logic unv_found;   // some live vertex is still unvisited
    logic start_ok;    // start vertex lies below the live count
    logic sp_zero;     // no parent frames on the stack
    logic out_free;    // output register can take a result
    logic emit_last;   // emit index points at the final vertex
    logic graph_empty; // no live vertices at all
  } dfs_status_t;

  // Index of the lowest set bit, zero when none is set
  function automatic logic [VIdxW-1:0] lowest_set(input logic [MaxVertices-1:0] vec);
    logic [VIdxW-1:0] pos;
    pos = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = VIdxW'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hdl/dfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer: takes requests, steps the walk, sweep and result phases and
// issues one command set per cycle to the datapath.
// ----------------------------------------------------------------------------
module dfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 kind_i,
  output logic                 in_stall_o,
  input  dfs_pkg::dfs_status_t sts_i,
  output dfs_pkg::dfs_cmd_t    cmd_o
);
  import dfs_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StRoot,
    StSweep,
    StWalk,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  // Command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (kind_i == KindRun) begin
            cmd_o.run_init = 1'b1;
            state_d        = StRoot;
          end else begin
            cmd_o.add_edge = 1'b1;
          end
        end
      end
      StRoot: begin
        if (sts_i.start_ok) begin
          cmd_o.disc_start = 1'b1;
          state_d          = StWalk;
        end else begin
          state_d = StSweep;
        end
      end
      StSweep: begin
        if (sts_i.unv_found) begin
          cmd_o.disc_sweep = 1'b1;
          state_d          = StWalk;
        end else if (sts_i.graph_empty) begin
          // nothing to report: just wipe the matrix
          cmd_o.clear_adj = 1'b1;
          state_d         = StIdle;
        end else begin
          state_d = StEmit;
        end
      end
      StWalk: begin
        if (sts_i.cand_found) begin
          cmd_o.disc_cand = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
          if (sts_i.sp_zero) begin
            state_d = StSweep;
          end
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear_adj = 1'b1;
            state_d         = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/dfs_dpath.sv =====
// ----------------------------------------------------------------------------
// dfs_dpath
// Datapath: configuration, adjacency matrix, visit marks, parent stack,
// time stamps and the result register.
// ----------------------------------------------------------------------------
module dfs_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dfs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dfs_pkg::CfgW-1:0]          cfg_data_i,
  input  logic [dfs_pkg::EdgeW-1:0]         edge_from_i,
  input  logic [dfs_pkg::EdgeW-1:0]         edge_to_i,
  input  dfs_pkg::dfs_cmd_t                 cmd_i,
  output dfs_pkg::dfs_status_t              sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dfs_pkg::OutIdxW-1:0]       vertex_index_o,
  output logic [dfs_pkg::OutTimW-1:0]       discovery_time_o,
  output logic [dfs_pkg::OutTimW-1:0]       finish_time_o,
  output logic                              last_result_o
);
  import dfs_pkg::*;

  // Configuration
  logic [VcW-1:0] vc_q;
  logic [SvW-1:0] sv_q;

  // Traversal state
  logic [MaxVertices-1:0] adj_q [MaxVertices];
  logic [MaxVertices-1:0] visited_q;
  logic [VIdxW-1:0]       stack_q [MaxVertices];
  logic [TimeW-1:0]       disc_q  [MaxVertices];
  logic [TimeW-1:0]       fin_q   [MaxVertices];
  logic [VIdxW-1:0]       u_q;
  logic [CntW-1:0]        sp_q;
  logic [TimeW-1:0]       time_q;
  logic [VIdxW-1:0]       emit_idx_q;

  // Result register
  logic                   out_valid_q;
  logic [OutIdxW-1:0]     out_idx_q;
  logic [OutTimW-1:0]     out_disc_q;
  logic [OutTimW-1:0]     out_fin_q;
  logic                   out_last_q;

  logic [CntW-1:0]        n_live;
  logic [MaxVertices-1:0] live;
  logic [MaxVertices-1:0] cand_vec;
  logic [MaxVertices-1:0] unv_vec;
  logic [VIdxW-1:0]       cand_idx;
  logic [VIdxW-1:0]       unv_idx;
  logic [VIdxW-1:0]       disc_v;
  logic                   discover;
  logic                   edge_ok;
  logic [TimeW-1:0]       time_inc;
  logic [CntW-1:0]        sp_m1;
  logic                   out_free;

  // Live vertex count, saturated at the array size
  assign n_live = (CntW'(vc_q) > CntW'(MaxVertices)) ? CntW'(MaxVertices) : CntW'(vc_q);

  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      live[i] = (CntW'(i) < n_live);
    end
  end

  // Neighbor and root search
  assign cand_vec = adj_q[u_q] & ~visited_q & live;
  assign unv_vec  = ~visited_q & live;
  assign cand_idx = lowest_set(cand_vec);
  assign unv_idx  = lowest_set(unv_vec);

  assign discover = cmd_i.disc_start || cmd_i.disc_sweep || cmd_i.disc_cand;
  assign disc_v   = cmd_i.disc_start ? VIdxW'(sv_q) :
                    cmd_i.disc_sweep ? unv_idx : cand_idx;
  assign time_inc = time_q + TimeW'(1);
  assign sp_m1    = sp_q - CntW'(1);
  assign edge_ok  = (CntW'(edge_from_i) < n_live) && (CntW'(edge_to_i) < n_live);
  assign out_free = !out_valid_q || !out_stall_i;

  // Status to the controller
  always_comb begin
    sts_o             = '0;
    sts_o.cand_found  = |cand_vec;
    sts_o.unv_found   = |unv_vec;
    sts_o.start_ok    = (CntW'(sv_q) < n_live);
    sts_o.sp_zero     = (sp_q == '0);
    sts_o.out_free    = out_free;
    sts_o.emit_last   = (CntW'(emit_idx_q) == (n_live - CntW'(1)));
    sts_o.graph_empty = (n_live == '0);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VertexCountRst;
      sv_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgVertexCount: vc_q <= VcW'(cfg_data_i);
        CfgStartVertex: sv_q <= cfg_data_i[SvW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Adjacency matrix: bit set on edge add, full wipe after a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxVertices; r++) begin
        adj_q[r] <= '0;
      end
    end else if (cmd_i.clear_adj) begin
      for (int r = 0; r < MaxVertices; r++) begin
        adj_q[r] <= '0;
      end
    end else if (cmd_i.add_edge && edge_ok) begin
      adj_q[edge_from_i[VIdxW-1:0]][edge_to_i[VIdxW-1:0]] <= 1'b1;
    end
  end

  // Walk control: marks, current vertex, stack pointer, clock, emit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q  <= '0;
      u_q        <= '0;
      sp_q       <= '0;
      time_q     <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.run_init) begin
        visited_q  <= '0;
        sp_q       <= '0;
        time_q     <= '0;
        emit_idx_q <= '0;
      end
      if (discover) begin
        visited_q[disc_v] <= 1'b1;
        u_q               <= disc_v;
        time_q            <= time_inc;
        if (cmd_i.disc_cand) begin
          sp_q <= sp_q + CntW'(1);
        end
      end
      if (cmd_i.finish) begin
        time_q <= time_inc;
        if (sp_q != '0) begin
          u_q  <= stack_q[sp_m1[VIdxW-1:0]];
          sp_q <= sp_m1;
        end
      end
      if (cmd_i.emit) begin
        emit_idx_q <= emit_idx_q + VIdxW'(1);
      end
    end
  end

  // Stack frames and time stamps
  always_ff @(posedge clk_i) begin
    if (cmd_i.disc_cand) begin
      stack_q[sp_q[VIdxW-1:0]] <= u_q;
    end
    if (discover) begin
      disc_q[disc_v] <= time_inc;
    end
    if (cmd_i.finish) begin
      fin_q[u_q] <= time_inc;
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q  <= OutIdxW'(emit_idx_q);
      out_disc_q <= OutTimW'(disc_q[emit_idx_q]);
      out_fin_q  <= OutTimW'(fin_q[emit_idx_q]);
      out_last_q <= sts_o.emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign vertex_index_o   = out_idx_q;
  assign discovery_time_o = out_disc_q;
  assign finish_time_o    = out_fin_q;
  assign last_result_o    = out_last_q;

`ifndef SYNTHESIS
  // A discovered neighbor must not have been reached before
  a_cand_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.disc_cand |-> !visited_q[cand_idx])
    else $error("candidate vertex already visited");

  // Stamps never pass twice the live vertex count
  a_time_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (discover || cmd_i.finish) |-> (time_q < {n_live, 1'b0}))
    else $error("time counter overrun");

  // Every live vertex is stamped before results go out
  a_all_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> ((visited_q & live) == live))
    else $error("result emitted before traversal complete");

  // The stack never grows past the vertex count
  a_stack_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.disc_cand |-> (sp_q < (n_live - CntW'(1))))
    else $error("stack overflow");

  // Results are only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

// ===== hdl/dfs_discovery_finish_times.sv =====
// ----------------------------------------------------------------------------
// dfs_discovery_finish_times
// Depth first search discovery and finish times over a directed graph.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes requests. kind_i = 0 adds
//   the edge edge_from_i -> edge_to_i; edges with an end at or above the
//   live vertex count are dropped. An edge request leaves the block idle,
//   so edge loads stream at one per cycle. kind_i = 1 starts a run.
//   A run walks depth first from start_vertex (if in range), then from each
//   unvisited vertex in index order. Once the request is accepted the block
//   checks the start vertex, walks discovering or finishing one vertex at a
//   time (a root is discovered in its start or sweep check), makes a final
//   sweep check, then loads the results one at a time. All stamps come from
//   the single shared search and stamp datapath; in_stall_o is high for the
//   whole run. With no live vertices a run gives no results.
//   Output channel (out_valid_o / out_stall_i) gives n results, vertex 0
//   first, last_result_o on the final one. A result sits in an output
//   register; while out_stall_i is high the run waits before the next one.
//   After the last result is loaded the adjacency matrix is cleared and new
//   requests are taken even if that result is still waiting.
//   Reset clears the matrix, sets vertex_count to 32 and start_vertex to 0.
// ----------------------------------------------------------------------------
module dfs_discovery_finish_times (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dfs_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [dfs_pkg::EdgeW-1:0]     edge_from_i,
  input  logic [dfs_pkg::EdgeW-1:0]     edge_to_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dfs_pkg::OutIdxW-1:0]   vertex_index_o,
  output logic [dfs_pkg::OutTimW-1:0]   discovery_time_o,
  output logic [dfs_pkg::OutTimW-1:0]   finish_time_o,
  output logic                          last_result_o
);
  import dfs_pkg::*;

  dfs_cmd_t    cmd;
  dfs_status_t sts;

  // Sequencer
  dfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and stamping
  dfs_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .edge_from_i      (edge_from_i),
    .edge_to_i        (edge_to_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vertex_index_o   (vertex_index_o),
    .discovery_time_o (discovery_time_o),
    .finish_time_o    (finish_time_o),
    .last_result_o    (last_result_o)
  );

endmodule

// ===== dv/tb_dfs_discovery_finish_times.sv =====
// ----------------------------------------------------------------------------
// tb_dfs_discovery_finish_times
// Self-checking bench for the depth first search discovery/finish time block.
// Edge and run requests go in over the valid/stall input channel. A local
// model of the adjacency matrix and of the walk predicts every vertex's
// discovery and finish stamps on each run. Each result is checked field by
// field against the oldest prediction. Directed cases come first, then
// random graphs with random idling on both channels, then a stretch with no
// idling at all.
// ----------------------------------------------------------------------------
module tb_dfs_discovery_finish_times;
  import dfs_pkg::*;

  localparam int SettleCycles = 200;
  localparam int RandomTarget = 290;

  typedef enum logic [1:0] {
    MarkUnseen,
    MarkVisited,
    MarkFinished
  } mark_e;

  typedef struct {
    logic [OutIdxW-1:0] vertex;
    logic [OutTimW-1:0] disc;
    logic [OutTimW-1:0] fin;
    logic               last;
  } vertex_times_t;

  // DUT signals; the bench-driven inputs are known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               kind_i      = 1'b0;
  logic [EdgeW-1:0]   edge_from_i = '0;
  logic [EdgeW-1:0]   edge_to_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [OutIdxW-1:0] vertex_index_o;
  logic [OutTimW-1:0] discovery_time_o;
  logic [OutTimW-1:0] finish_time_o;
  logic               last_result_o;

  // Bench control
  int error_count   = 0;
  int requests_sent = 0;
  bit no_idle       = 1'b0;
  int stall_left    = 0;

  // Local copy of the graph, the walk state and the registers
  logic [MaxVertices-1:0] adj_rows [MaxVertices];
  mark_e                  walk_marks [MaxVertices];
  logic [OutTimW-1:0]     disc_stamp [MaxVertices];
  logic [OutTimW-1:0]     fin_stamp [MaxVertices];
  int                     stack_vertex [MaxVertices];
  int                     stack_next [MaxVertices];
  int                     stack_top;
  int                     stamp_count;
  logic [VcW-1:0]         vertex_count_q = VcW'(32);
  logic [SvW-1:0]         start_vertex_q = '0;

  vertex_times_t expected_times [$];

  dfs_discovery_finish_times dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .edge_from_i      (edge_from_i),
    .edge_to_i        (edge_to_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vertex_index_o   (vertex_index_o),
    .discovery_time_o (discovery_time_o),
    .finish_time_o    (finish_time_o),
    .last_result_o    (last_result_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Walk model
  // ---------------------------------------------------------------------------
  function automatic int live_vertices();
    if (vertex_count_q > VcW'(MaxVertices)) return MaxVertices;
    return int'(vertex_count_q);
  endfunction

  function automatic void mark_discovered(int v);
    stamp_count++;
    disc_stamp[v] = OutTimW'(stamp_count);
    walk_marks[v] = MarkVisited;
    stack_vertex[stack_top] = v;
    stack_next[stack_top]   = 0;
    stack_top++;
  endfunction

  // One depth first tree from root; neighbors scanned in index order
  function automatic void depth_walk(int root, int n);
    int u;
    int i;
    bit found;
    mark_discovered(root);
    while (stack_top > 0) begin
      u     = stack_vertex[stack_top-1];
      i     = stack_next[stack_top-1];
      found = 1'b0;
      while (i < n && !found) begin
        if (adj_rows[u][i] && walk_marks[i] == MarkUnseen) found = 1'b1;
        else i++;
      end
      if (found) begin
        stack_next[stack_top-1] = i + 1;
        mark_discovered(i);
      end else begin
        walk_marks[u] = MarkFinished;
        stamp_count++;
        fin_stamp[u] = OutTimW'(stamp_count);
        stack_top--;
      end
    end
  endfunction

  // Apply one accepted request; a run queues one time pair per vertex
  function automatic void predict_times(logic kind, logic [EdgeW-1:0] from,
                                        logic [EdgeW-1:0] to);
    int n;
    vertex_times_t t;
    n = live_vertices();
    if (kind == KindAddEdge) begin
      if (int'(from) < n && int'(to) < n) adj_rows[from][to] = 1'b1;
    end else begin
      for (int v = 0; v < n; v++) walk_marks[v] = MarkUnseen;
      stamp_count = 0;
      stack_top   = 0;
      if (int'(start_vertex_q) < n) depth_walk(int'(start_vertex_q), n);
      for (int v = 0; v < n; v++) begin
        if (walk_marks[v] == MarkUnseen) depth_walk(v, n);
      end
      for (int v = 0; v < n; v++) begin
        t.vertex = OutIdxW'(v);
        t.disc   = disc_stamp[v];
        t.fin    = fin_stamp[v];
        t.last   = (v + 1 == n);
        expected_times.push_back(t);
      end
      for (int r = 0; r < MaxVertices; r++) adj_rows[r] = '0;
    end
  endfunction

  initial begin
    for (int r = 0; r < MaxVertices; r++) adj_rows[r] = '0;
    stack_top   = 0;
    stamp_count = 0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted requests, check accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    vertex_times_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_times(kind_i, edge_from_i, edge_to_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_times.size() == 0) begin
          $error("unexpected result: vertex_index %0d", vertex_index_o);
          error_count++;
        end else begin
          want = expected_times.pop_front();
          if (vertex_index_o !== want.vertex) begin
            $error("vertex_index mismatch: expected %0d, actual %0d",
                   want.vertex, vertex_index_o);
            error_count++;
          end
          if (discovery_time_o !== want.disc) begin
            $error("discovery_time mismatch: expected %0d, actual %0d",
                   want.disc, discovery_time_o);
            error_count++;
          end
          if (finish_time_o !== want.fin) begin
            $error("finish_time mismatch: expected %0d, actual %0d",
                   want.fin, finish_time_o);
            error_count++;
          end
          if (last_result_o !== want.last) begin
            $error("last_result mismatch: expected %0d, actual %0d",
                   want.last, last_result_o);
            error_count++;
          end
        end
      end
    end
  end

  // Output back-pressure in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks; each is entered and left on a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_request(logic kind, logic [EdgeW-1:0] from, logic [EdgeW-1:0] to);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    edge_from_i <= from;
    edge_to_i   <= to;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
  endtask

  // Wait until every predicted result is back and the block has settled
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_times.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CfgVertexCount) vertex_count_q = data;
    else start_vertex_q = data[SvW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random register setting, a random or path shaped graph, then a run
  task automatic send_random_graph();
    int pick;
    int n;
    int edge_total;
    bit reverse;
    logic [VcW-1:0] vc;
    logic [SvW-1:0] sv;
    logic [EdgeW-1:0] from;
    logic [EdgeW-1:0] to;
    pick = $urandom_range(0, 19);
    if (pick == 0) vc = '0;
    else if (pick == 1) vc = VcW'($urandom_range(33, 63));
    else if (pick <= 4) vc = VcW'(32);
    else if (pick == 5) vc = VcW'(1);
    else vc = VcW'($urandom_range(2, 31));
    write_reg(CfgVertexCount, vc);
    n = live_vertices();
    if ($urandom_range(0, 9) < 6) begin
      if (n > 0 && $urandom_range(0, 9) < 8) sv = SvW'($urandom_range(0, n - 1));
      else sv = SvW'($urandom_range(0, 31));
      write_reg(CfgStartVertex, {1'($urandom_range(0, 1)), sv});
    end
    if (n > 1 && $urandom_range(0, 5) == 0) begin
      // chain through every vertex: deepest stack
      reverse = 1'($urandom_range(0, 1));
      for (int v = 0; v < n - 1; v++) begin
        if (reverse) send_request(KindAddEdge, EdgeW'(v + 1), EdgeW'(v));
        else send_request(KindAddEdge, EdgeW'(v), EdgeW'(v + 1));
      end
    end else begin
      edge_total = $urandom_range(0, 24);
      repeat (edge_total) begin
        if (n > 0 && $urandom_range(0, 7) != 0) begin
          from = EdgeW'($urandom_range(0, n - 1));
          to   = EdgeW'($urandom_range(0, n - 1));
        end else begin
          from = EdgeW'($urandom_range(0, 63));
          to   = EdgeW'($urandom_range(0, 63));
        end
        send_request(KindAddEdge, from, to);
      end
    end
    send_request(KindRun, EdgeW'($urandom_range(0, 63)), EdgeW'($urandom_range(0, 63)));
    // occasional second run on the freshly cleared matrix
    if ($urandom_range(0, 9) == 0) send_request(KindRun, '0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings, no edges: every vertex is its own tree
  task automatic test_empty_graph();
    send_request(KindRun, '0, '0);
  endtask

  // Corner vertices, self loop and dropped out-of-range ends
  task automatic test_edge_extremes();
    send_request(KindAddEdge, 6'd0, 6'd31);
    send_request(KindAddEdge, 6'd31, 6'd0);
    send_request(KindAddEdge, 6'd31, 6'd31);
    send_request(KindAddEdge, 6'd63, 6'd0);
    send_request(KindAddEdge, 6'd0, 6'd63);
    send_request(KindAddEdge, 6'd32, 6'd1);
    send_request(KindAddEdge, 6'd1, 6'd32);
    send_request(KindAddEdge, 6'd63, 6'd63);
    send_request(KindAddEdge, 6'd5, 6'd6);
    send_request(KindRun, 6'd63, 6'd63);
  endtask

  // Vertex count zero, above range and one
  task automatic test_vertex_count_cases();
    write_reg(CfgVertexCount, 6'd0);
    send_request(KindAddEdge, 6'd0, 6'd0);
    send_request(KindRun, '0, '0);
    write_reg(CfgVertexCount, 6'd63);
    send_request(KindAddEdge, 6'd2, 6'd30);
    send_request(KindRun, '0, '0);
    write_reg(CfgVertexCount, 6'd1);
    send_request(KindAddEdge, 6'd0, 6'd0);
    send_request(KindRun, '0, '0);
  endtask

  // Start at or above the vertex count: sweep only
  task automatic test_start_out_of_range();
    write_reg(CfgVertexCount, 6'd4);
    write_reg(CfgStartVertex, 6'h3f);
    send_request(KindAddEdge, 6'd3, 6'd0);
    send_request(KindAddEdge, 6'd1, 6'd2);
    send_request(KindRun, '0, '0);
  endtask

  // Bits set under a large count are ignored once the count shrinks
  task automatic test_stale_bits();
    write_reg(CfgVertexCount, 6'd32);
    write_reg(CfgStartVertex, 6'd2);
    send_request(KindAddEdge, 6'd2, 6'd20);
    send_request(KindAddEdge, 6'd2, 6'd1);
    send_request(KindAddEdge, 6'd20, 6'd0);
    write_reg(CfgVertexCount, 6'd8);
    send_request(KindRun, '0, '0);
  endtask

  task automatic test_random_graphs();
    while (requests_sent < RandomTarget) send_random_graph();
  endtask

  // Full rate on both channels
  task automatic test_back_to_back();
    drain_results();
    no_idle = 1'b1;
    repeat (2) send_random_graph();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_graph();
    test_edge_extremes();
    test_vertex_count_cases();
    test_start_out_of_range();
    test_stale_bits();
    test_random_graphs();
    test_back_to_back();
    drain_results();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #16000000;
    $display("FAIL");
    $finish;
  end

endmodule
